/* rtl/afk_pkg.sv */
package afk_pkg;

   localparam int TRIG_ITERATIONS_DEF = 16;
   localparam int LENGTH_BITS_DEF     = 16;

   localparam int ANGLE_W = 16;
   localparam int TRIG_W  = 16;
   localparam int POS_W   = 18;
   localparam int CX_W    = 33;
   localparam int CZ_W    = 25;
   localparam int CSR_IDX_W = 3;

   localparam int FULL_TURN    = 23040;
   localparam int HALF_TURN    = 11520;
   localparam int QUARTER_TURN = 5760;
   localparam int CORDIC_GAIN  = 652032874;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE  = 3'd0,
      CSR_UPPER = 3'd1,
      CSR_FORE  = 3'd2,
      CSR_TOOL  = 3'd3,
      CSR_DROP  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [CZ_W-1:0] z;
      logic                   neg;
   } angle_type;

   function automatic logic signed [CZ_W-1:0] atan_deg(input int i);
      logic signed [CZ_W-1:0] a;
      case (i)
         0:  a = 25'sd2949120;
         1:  a = 25'sd1740967;
         2:  a = 25'sd919879;
         3:  a = 25'sd466945;
         4:  a = 25'sd234379;
         5:  a = 25'sd117304;
         6:  a = 25'sd58666;
         7:  a = 25'sd29335;
         8:  a = 25'sd14668;
         9:  a = 25'sd7334;
         10: a = 25'sd3667;
         11: a = 25'sd1833;
         12: a = 25'sd917;
         13: a = 25'sd458;
         14: a = 25'sd229;
         15: a = 25'sd115;
         16: a = 25'sd57;
         17: a = 25'sd29;
         18: a = 25'sd14;
         19: a = 25'sd7;
         20: a = 25'sd4;
         21: a = 25'sd2;
         22: a = 25'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

/* rtl/afk_if.sv */
interface afk_req_if;
   import afk_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] first_angle;
   logic signed [ANGLE_W-1:0] second_angle;
   modport source (output valid, first_angle, second_angle, input ready);
   modport sink (input valid, first_angle, second_angle, output ready);
endinterface

interface afk_rsp_if;
   import afk_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [TRIG_W-1:0] cos_total;
   logic signed [TRIG_W-1:0] sin_total;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [POS_W-1:0]  pos_z;
   modport source (output valid, cos_total, sin_total, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, cos_total, sin_total, pos_x, pos_y, pos_z, output ready);
endinterface

/* rtl/afk_cordic.sv */
module afk_cordic #(
   parameter int TRIG_ITERATIONS = afk_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                             clock,
   input  logic                             advance,
   input  afk_pkg::angle_type               angle,
   output logic signed [afk_pkg::CX_W-1:0]  cos_out,
   output logic signed [afk_pkg::CX_W-1:0]  sin_out
);
   import afk_pkg::*;

   logic signed [CX_W-1:0] x_ff [TRIG_ITERATIONS];
   logic signed [CX_W-1:0] y_ff [TRIG_ITERATIONS];
   logic signed [CZ_W-1:0] z_ff [TRIG_ITERATIONS];
   logic                   neg_ff [TRIG_ITERATIONS];

   for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_step
      logic signed [CX_W-1:0] x_prev, y_prev, x_in, y_in;
      logic signed [CZ_W-1:0] z_prev, z_in;
      logic                   neg_prev;

      if (i == 0) begin : g_first
         assign x_prev   = CX_W'(CORDIC_GAIN);
         assign y_prev   = '0;
         assign z_prev   = angle.z;
         assign neg_prev = angle.neg;
      end else begin : g_next
         assign x_prev   = x_ff[i-1];
         assign y_prev   = y_ff[i-1];
         assign z_prev   = z_ff[i-1];
         assign neg_prev = neg_ff[i-1];
      end

      always_comb begin
         if (!z_prev[CZ_W-1]) begin
            x_in = x_prev - (y_prev >>> i);
            y_in = y_prev + (x_prev >>> i);
            z_in = z_prev - atan_deg(i);
         end else begin
            x_in = x_prev + (y_prev >>> i);
            y_in = y_prev - (x_prev >>> i);
            z_in = z_prev + atan_deg(i);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in;
            neg_ff[i] <= neg_prev;
         end
      end
   end

   assign cos_out = neg_ff[TRIG_ITERATIONS-1] ? -x_ff[TRIG_ITERATIONS-1]
                                              : x_ff[TRIG_ITERATIONS-1];
   assign sin_out = neg_ff[TRIG_ITERATIONS-1] ? -y_ff[TRIG_ITERATIONS-1]
                                              : y_ff[TRIG_ITERATIONS-1];

endmodule

/* rtl/arm_forward_kinematics.sv */
// Requests pass the angle register, CORDIC stages, product and output registers.
// Throughput: one request per cycle; the two CORDIC pipelines run one rotation
// step per stage, and the whole pipeline holds while a result waits.
// Reset clears the stage valid bits and all link registers to zero.
// Link registers are meant to be written only while the pipeline is empty.
module arm_forward_kinematics #(
   parameter int TRIG_ITERATIONS = afk_pkg::TRIG_ITERATIONS_DEF,
   parameter int LENGTH_BITS     = afk_pkg::LENGTH_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   afk_req_if.sink                           req,
   afk_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [afk_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [LENGTH_BITS-1:0]            csr_wdata
);
   import afk_pkg::*;

   localparam int PW = LENGTH_BITS + 34;

   logic [LENGTH_BITS-1:0] base_ff, upper_ff, fore_ff, tool_ff, drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         upper_ff <= '0;
         fore_ff  <= '0;
         tool_ff  <= '0;
         drop_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE:  base_ff  <= csr_wdata;
            CSR_UPPER: upper_ff <= csr_wdata;
            CSR_FORE:  fore_ff  <= csr_wdata;
            CSR_TOOL:  tool_ff  <= csr_wdata;
            CSR_DROP:  drop_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic angle_type reduce_angle(input logic signed [ANGLE_W:0] v);
      logic [17:0]        t;
      logic signed [15:0] r;
      angle_type          a;
      t = 18'($signed({v[ANGLE_W], v}) + 18'sd69120);
      if (t >= 18'(5 * FULL_TURN))      t = t - 18'(5 * FULL_TURN);
      else if (t >= 18'(4 * FULL_TURN)) t = t - 18'(4 * FULL_TURN);
      else if (t >= 18'(3 * FULL_TURN)) t = t - 18'(3 * FULL_TURN);
      else if (t >= 18'(2 * FULL_TURN)) t = t - 18'(2 * FULL_TURN);
      else if (t >= 18'(FULL_TURN))     t = t - 18'(FULL_TURN);
      r = signed'(16'(t));
      if (r >= 16'sd11520) r = r - 16'sd23040;
      a.neg = 1'b0;
      if (r > 16'sd5760) begin
         r = r - 16'sd11520;
         a.neg = 1'b1;
      end else if (r < -16'sd5760) begin
         r = r + 16'sd11520;
         a.neg = 1'b1;
      end
      a.z = CZ_W'(r) <<< 10;
      return a;
   endfunction

   logic advance;
   logic v0_ff, v1_ff, v2_ff;
   logic vc_ff [TRIG_ITERATIONS];

   assign advance   = !v2_ff || rsp.ready;
   assign req.ready = advance;

   angle_type a1_ff, a12_ff;
   logic signed [ANGLE_W:0] sum_angle;

   assign sum_angle = {req.first_angle[ANGLE_W-1], req.first_angle}
                    + {req.second_angle[ANGLE_W-1], req.second_angle};

   always_ff @(posedge clock) begin
      if (advance) begin
         a1_ff  <= reduce_angle({req.first_angle[ANGLE_W-1], req.first_angle});
         a12_ff <= reduce_angle(sum_angle);
      end
   end

   logic signed [CX_W-1:0] c1, s1, c12, s12;

   afk_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic_first (
      .clock   (clock),
      .advance (advance),
      .angle   (a1_ff),
      .cos_out (c1),
      .sin_out (s1)
   );

   afk_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic_total (
      .clock   (clock),
      .advance (advance),
      .angle   (a12_ff),
      .cos_out (c12),
      .sin_out (s12)
   );

   function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [CX_W-1:0] v);
      logic signed [CX_W-1:0] r;
      r = (v + CX_W'(16384)) >>> 15;
      if (r > CX_W'(32767))       return TRIG_W'(32767);
      else if (r < -CX_W'(32768)) return TRIG_W'(-32768);
      return TRIG_W'(r);
   endfunction

   function automatic logic signed [PW-1:0] quarter(input logic signed [CX_W-1:0] v);
      logic signed [CX_W-1:0] r;
      r = (v + CX_W'(2)) >>> 2;
      return PW'(r);
   endfunction

   function automatic logic signed [POS_W-1:0] pos_sat(input logic signed [PW-1:0] v);
      if (v > PW'(131071))       return POS_W'(131071);
      else if (v < -PW'(131072)) return POS_W'(-131072);
      return POS_W'(v);
   endfunction

   logic signed [PW-1:0]     l1, l2;
   logic signed [PW-1:0]     pxa_ff, pxb_ff, pya_ff, pyb_ff, pz_ff;
   logic signed [TRIG_W-1:0] ct_ff, st_ff;

   assign l1 = PW'({1'b0, upper_ff});
   assign l2 = PW'({1'b0, fore_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         pxa_ff <= l1 * quarter(s1);
         pxb_ff <= l2 * quarter(s12);
         pya_ff <= l1 * quarter(c1);
         pyb_ff <= l2 * quarter(c12);
         ct_ff  <= trig_round(c12);
         st_ff  <= trig_round(s12);
         pz_ff  <= PW'({1'b0, base_ff}) - PW'({1'b0, drop_ff}) - PW'({1'b0, tool_ff});
      end
   end

   logic signed [PW-1:0] px_sum, py_sum;
   logic signed [TRIG_W-1:0] ct_out_ff, st_out_ff;
   logic signed [POS_W-1:0]  px_out_ff, py_out_ff, pz_out_ff;

   assign px_sum = -(pxa_ff + pxb_ff);
   assign py_sum = pya_ff + pyb_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         ct_out_ff <= ct_ff;
         st_out_ff <= st_ff;
         px_out_ff <= pos_sat((px_sum + (PW'(1) <<< 27)) >>> 28);
         py_out_ff <= pos_sat((py_sum + (PW'(1) <<< 27)) >>> 28);
         pz_out_ff <= pos_sat(pz_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         for (int i = 0; i < TRIG_ITERATIONS; i++) vc_ff[i] <= 1'b0;
      end else if (advance) begin
         v0_ff    <= req.valid;
         vc_ff[0] <= v0_ff;
         for (int i = 1; i < TRIG_ITERATIONS; i++) vc_ff[i] <= vc_ff[i-1];
         v1_ff    <= vc_ff[TRIG_ITERATIONS-1];
         v2_ff    <= v1_ff;
      end
   end

   assign rsp.valid     = v2_ff;
   assign rsp.cos_total = ct_out_ff;
   assign rsp.sin_total = st_out_ff;
   assign rsp.pos_x     = px_out_ff;
   assign rsp.pos_y     = py_out_ff;
   assign rsp.pos_z     = pz_out_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp.valid && !v1_ff && !v0_ff)
      else $error("pipeline not empty after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> v0_ff == $past(v0_ff) && v1_ff == $past(v1_ff))
      else $error("stage valid changed during stall");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == CSR_UPPER |=> upper_ff == $past(csr_wdata))
      else $error("link register write lost");

endmodule

/* tb/tb_arm_forward_kinematics.sv */
module tb_arm_forward_kinematics;
   import afk_pkg::*;

   typedef struct {
      logic signed [TRIG_W-1:0] cos_total;
      logic signed [TRIG_W-1:0] sin_total;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
   } pose_type;

   localparam int ITERS = TRIG_ITERATIONS_DEF;
   localparam longint CYCLE_LIMIT = 400000;

   class pose_scoreboard;
      longint unsigned links[5];
      pose_type pending_poses[$];
      int errors;
      int checked;

      function longint rnd_shift(longint v, int s);
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function longint sat(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      task automatic rotate(longint ang, output longint c, output longint s);
         longint r;
         longint x;
         longint y;
         longint z;
         longint dx;
         longint dy;
         bit flip;
         r = ang % FULL_TURN;
         flip = 0;
         x = CORDIC_GAIN;
         y = 0;
         if (r < 0) r += FULL_TURN;
         if (r >= HALF_TURN) r -= FULL_TURN;
         if (r > QUARTER_TURN) begin
            r -= HALF_TURN;
            flip = 1;
         end else if (r < -QUARTER_TURN) begin
            r += HALF_TURN;
            flip = 1;
         end
         z = r * 1024;
         for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= longint'(atan_deg(i));
            end else begin
               x += dx;
               y -= dy;
               z += longint'(atan_deg(i));
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endtask

      task automatic note_request(logic signed [ANGLE_W-1:0] a1, logic signed [ANGLE_W-1:0] a2);
         longint c1;
         longint s1;
         longint c12;
         longint s12;
         longint px;
         longint py;
         pose_type p;
         rotate(longint'(a1), c1, s1);
         rotate(longint'(a1) + longint'(a2), c12, s12);
         px = -(longint'(links[CSR_UPPER]) * rnd_shift(s1, 2)
               + longint'(links[CSR_FORE]) * rnd_shift(s12, 2));
         py = longint'(links[CSR_UPPER]) * rnd_shift(c1, 2)
               + longint'(links[CSR_FORE]) * rnd_shift(c12, 2);
         p.cos_total = TRIG_W'(sat(rnd_shift(c12, 15), -32768, 32767));
         p.sin_total = TRIG_W'(sat(rnd_shift(s12, 15), -32768, 32767));
         p.pos_x = POS_W'(sat(rnd_shift(px, 28), -131072, 131071));
         p.pos_y = POS_W'(sat(rnd_shift(py, 28), -131072, 131071));
         p.pos_z = POS_W'(sat(longint'(links[CSR_BASE]) - longint'(links[CSR_DROP])
               - longint'(links[CSR_TOOL]), -131072, 131071));
         pending_poses.push_back(p);
      endtask

      task automatic check_pose(pose_type got);
         pose_type e;
         checked++;
         if (pending_poses.size() == 0) begin
            $error("Unexpected response with no request outstanding.");
            errors++;
            return;
         end
         e = pending_poses.pop_front();
         if (got.cos_total !== e.cos_total) begin
            $error("cos_total expected %0d actual %0d", e.cos_total, got.cos_total);
            errors++;
         end
         if (got.sin_total !== e.sin_total) begin
            $error("sin_total expected %0d actual %0d", e.sin_total, got.sin_total);
            errors++;
         end
         if (got.pos_x !== e.pos_x) begin
            $error("pos_x expected %0d actual %0d", e.pos_x, got.pos_x);
            errors++;
         end
         if (got.pos_y !== e.pos_y) begin
            $error("pos_y expected %0d actual %0d", e.pos_y, got.pos_y);
            errors++;
         end
         if (got.pos_z !== e.pos_z) begin
            $error("pos_z expected %0d actual %0d", e.pos_z, got.pos_z);
            errors++;
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LENGTH_BITS_DEF-1:0] csr_wdata;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   longint cycle_count;
   int sent;
   pose_scoreboard board;

   afk_req_if req_if ();
   afk_rsp_if rsp_if ();

   arm_forward_kinematics i_dut (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if.sink),
      .rsp      (rsp_if.source),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      board = new();
      reset = 1;
      req_if.valid = 0;
      req_if.first_angle = '0;
      req_if.second_angle = '0;
      rsp_if.ready = 0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 0;
      cycle_count = 0;
      sent = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit.");
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         board.check_pose('{rsp_if.cos_total, rsp_if.sin_total,
               rsp_if.pos_x, rsp_if.pos_y, rsp_if.pos_z});
      end
   end

   task automatic send_request(logic signed [ANGLE_W-1:0] a1, logic signed [ANGLE_W-1:0] a2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 0;
         @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.first_angle <= a1;
      req_if.second_angle <= a2;
      do @(posedge clock); while (!req_if.ready);
      board.note_request(a1, a2);
      sent++;
   endtask

   task automatic write_link(csr_index_type idx, logic [15:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.links[idx] = value;
   endtask

   task automatic drain();
      req_if.valid <= 0;
      while (board.pending_poses.size() != 0) @(posedge clock);
      repeat (ITERS + 8) @(posedge clock);
   endtask

   task automatic set_links(logic [15:0] l0, logic [15:0] l1, logic [15:0] l2,
         logic [15:0] l3, logic [15:0] off);
      drain();
      write_link(CSR_BASE, l0);
      write_link(CSR_UPPER, l1);
      write_link(CSR_FORE, l2);
      write_link(CSR_TOOL, l3);
      write_link(CSR_DROP, off);
      csr_we <= 0;
   endtask

   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      case ($urandom_range(9))
         0: return ANGLE_W'($urandom());
         1: return ANGLE_W'(($urandom_range(8) - 4) * QUARTER_TURN + $urandom_range(2) - 1);
         default: return ANGLE_W'($urandom_range(2 * FULL_TURN) - FULL_TURN);
      endcase
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) send_request(pick_angle(), pick_angle());
   endtask

   initial begin
      logic signed [ANGLE_W-1:0] edges[12];
      edges = '{16'sh7fff, -16'sh8000, 0, QUARTER_TURN, -QUARTER_TURN, HALF_TURN,
            -HALF_TURN, FULL_TURN, -FULL_TURN, QUARTER_TURN + 1, -QUARTER_TURN - 1,
            16'sh5555};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int i = 0; i < 12; i++) send_request(edges[i], edges[11 - i]);
      set_links(16'hffff, 16'hffff, 16'hffff, 0, 0);
      for (int i = 0; i < 12; i++) send_request(edges[i], edges[(i + 5) % 12]);

      set_links(0, 0, 0, 16'hffff, 16'hffff);
      send_idle_pct = 25;
      recv_idle_pct = 81;
      random_phase(150);

      set_links(16'd1600, 16'd4000, 16'd3200, 16'd480, 16'd160);
      send_idle_pct = 81;
      recv_idle_pct = 25;
      random_phase(150);

      set_links(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
            16'($urandom()));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 200;
      random_phase(250);

      set_links(16'hffff, 16'h8000, 16'h7fff, 16'h0001, 16'hfffe);
      random_phase(240);

      drain();
      $display("Sent %0d angle requests over six link settings; checked %0d poses.",
            sent, board.checked);
      if (board.errors == 0 && board.pending_poses.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
